@@ rtl/hdlc_drs_pkg.sv @@
// Package for the HDLC de-framing and re-stuffing block.
// Holds the framing constants, the receive mode type and the stuffing helper.
// Depends on nothing.
`timescale 1ns / 1ps

package hdlc_drs_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned MAX_RESULTS = 5;
  localparam int unsigned RES_CNT_W = 3;
  localparam int unsigned MAX_FRAME_BYTES_DEF = 512;

  localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h7D;
  localparam logic [BYTE_W-1:0] XOR_MASK = 8'h20;
  localparam logic [BYTE_W-1:0] CTRL_CHAN_RST = 8'h04;
  localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'h00;

  typedef enum logic [1:0] {
    MODE_WAIT  = 2'd0,
    MODE_FRAME = 2'd1,
    MODE_ESC   = 2'd2
  } rx_mode_t;

  typedef struct packed {
    logic [1:0]          len;
    logic [2*BYTE_W-1:0] bytes;
  } stuffed_t;

  function automatic stuffed_t stuff_byte(input logic [BYTE_W-1:0] c);
    stuffed_t s;
    if ((c == FLAG_BYTE) || (c == ESC_BYTE)) begin
      s.len = 2'd2;
      s.bytes = {c ^ XOR_MASK, ESC_BYTE};
    end else begin
      s.len = 2'd1;
      s.bytes = {8'h00, c};
    end
    return s;
  endfunction

endpackage

@@ rtl/hdlc_dlci_deframe_restuff.sv @@
// Top level of the HDLC de-framing and re-stuffing block.
// Uses hdlc_drs_pkg for constants, the mode type and the stuffing helper.
//
//   channel   direction  contents
//   s_*       in         one received byte per beat
//   m_*       out        one byte for the receive FIFO per beat
//   cfg_*     in         control channel number, written when cfg_we is high
//
// Each input beat is decoded into zero to five result bytes, which sit in
// a result register and leave one per cycle on the output side while m_tready is high.
// A new input beat is taken only when no result byte is pending or while
// the last pending result byte is sent.
// Reset is synchronous and puts the block back to waiting for the first flag.
// A stall on the output side holds the result register and the input side.
`timescale 1ns / 1ps

module hdlc_dlci_deframe_restuff #(
  parameter int unsigned MAX_FRAME_BYTES = hdlc_drs_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [hdlc_drs_pkg::BYTE_W-1:0]  s_tdata,   // rx_byte
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [hdlc_drs_pkg::BYTE_W-1:0]  m_tdata,   // fifo_byte
  input  logic                             cfg_we,
  input  logic [hdlc_drs_pkg::BYTE_W-1:0]  cfg_wdata  // control_channel
);
  import hdlc_drs_pkg::*;

  localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_FRAME_BYTES);
  localparam int unsigned LIST_W = MAX_RESULTS * BYTE_W;

  logic [BYTE_W-1:0]    control_channel;
  rx_mode_t             rx_mode, rx_mode_next;
  logic [COUNT_W-1:0]   frame_count, frame_count_next;
  logic [BYTE_W-1:0]    held_first, held_first_next;
  logic                 diverted_frame, diverted_frame_next;
  logic [LIST_W-1:0]    res_buf, res_list;
  logic [RES_CNT_W-1:0] res_cnt, res_n;

  logic accept;
  logic pop;

  assign m_tvalid = (res_cnt != '0);
  assign m_tdata = res_buf[BYTE_W-1:0];
  assign pop = m_tvalid && m_tready;
  assign s_tready = (res_cnt == '0) || ((res_cnt == RES_CNT_W'(1)) && m_tready);
  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_channel <= CTRL_CHAN_RST;
    end else if (cfg_we) begin
      control_channel <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode <= MODE_WAIT;
      frame_count <= '0;
      held_first <= '0;
      diverted_frame <= 1'b0;
      res_cnt <= '0;
    end else if (accept) begin
      rx_mode <= rx_mode_next;
      frame_count <= frame_count_next;
      held_first <= held_first_next;
      diverted_frame <= diverted_frame_next;
      res_cnt <= res_n;
    end else if (pop) begin
      res_cnt <= res_cnt - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_buf <= res_list;
    end else if (pop) begin
      res_buf <= res_buf >> BYTE_W;
    end
  end

  always_comb begin
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] c;
    logic              take;
    stuffed_t          s1;
    stuffed_t          s2;

    b = s_tdata;
    c = b;
    take = 1'b0;
    rx_mode_next = rx_mode;
    frame_count_next = frame_count;
    held_first_next = held_first;
    diverted_frame_next = diverted_frame;
    res_list = '0;
    res_n = '0;

    case (rx_mode)
      MODE_ESC: begin
        rx_mode_next = MODE_FRAME;
        c = b ^ XOR_MASK;
        take = 1'b1;
      end
      MODE_FRAME: begin
        if (b == FLAG_BYTE) begin
          if (frame_count >= COUNT_W'(2)) begin
            res_list[BYTE_W-1:0] = diverted_frame ? MARKER_BYTE : FLAG_BYTE;
            res_n = RES_CNT_W'(1);
          end
          frame_count_next = '0;
          diverted_frame_next = 1'b0;
        end else if (b == ESC_BYTE) begin
          rx_mode_next = MODE_ESC;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        if (b == FLAG_BYTE) begin
          rx_mode_next = MODE_FRAME;
          frame_count_next = '0;
          diverted_frame_next = 1'b0;
        end else begin
          rx_mode_next = MODE_WAIT;
          res_list[BYTE_W-1:0] = b;
          res_n = RES_CNT_W'(1);
        end
      end
    endcase

    s1 = stuff_byte(held_first);
    s2 = stuff_byte(c);

    if (take && (frame_count < MAX_CNT)) begin
      if (frame_count == '0) begin
        held_first_next = c;
        diverted_frame_next = (c == control_channel);
        frame_count_next = COUNT_W'(1);
      end else if (frame_count == COUNT_W'(1)) begin
        frame_count_next = COUNT_W'(2);
        if (!diverted_frame) begin
          res_list[BYTE_W-1:0] = FLAG_BYTE;
          res_list[3*BYTE_W-1:BYTE_W] = s1.bytes;
          if (s1.len == 2'd2) begin
            res_list[5*BYTE_W-1:3*BYTE_W] = s2.bytes;
          end else begin
            res_list[4*BYTE_W-1:2*BYTE_W] = s2.bytes;
          end
          res_n = RES_CNT_W'(1) + RES_CNT_W'(s1.len) + RES_CNT_W'(s2.len);
        end
      end else begin
        frame_count_next = frame_count + COUNT_W'(1);
        if (!diverted_frame) begin
          res_list[2*BYTE_W-1:0] = s2.bytes;
          res_n = RES_CNT_W'(s2.len);
        end
      end
    end
  end

endmodule
